// File: rtl/nrtp_pkg.sv
// Package for the nested region time profiler.
// Operation codes, status codes, register indexes and the stat entry type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package nrtp_pkg;

	localparam int ID_W     = 6;
	localparam int TS_W     = 48;
	localparam int CNT_W    = 32;
	localparam int TOT_W    = 64;
	localparam int DEPTH_W  = 5;
	localparam int STATUS_W = 3;
	localparam int CFG_W    = 7;

	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_END   = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;
	localparam logic [1:0] OP_READ  = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
	localparam logic [STATUS_W-1:0] ST_DISABLED   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_REGION = 3'd2;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_UNDERFLOW  = 3'd4;
	localparam logic [STATUS_W-1:0] ST_MISMATCH   = 3'd5;
	localparam logic [STATUS_W-1:0] ST_NEG_TIME   = 3'd6;
	localparam logic [STATUS_W-1:0] ST_NESTED_CLR = 3'd7;

	localparam logic CFG_ENABLE  = 1'b0;
	localparam logic CFG_REGIONS = 1'b1;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic [TOT_W-1:0] incl;
		logic [TOT_W-1:0] excl;
	} stat_t;

endpackage : nrtp_pkg

`default_nettype wire

// File: rtl/nrtp_stat_mem.sv
// Per-region statistics memory: one read port, one write port, registered read.
// Depends on nrtp_pkg for the stat entry type.
`timescale 1ns / 1ps
`default_nettype none

module nrtp_stat_mem #(
	parameter int REGIONS = 64
) (
	input  wire logic                        clk,
	input  wire logic                        re,
	input  wire logic [$clog2(REGIONS)-1:0]  raddr,
	output nrtp_pkg::stat_t                  rdata,
	input  wire logic                        we,
	input  wire logic [$clog2(REGIONS)-1:0]  waddr,
	input  wire nrtp_pkg::stat_t             wdata
);
	import nrtp_pkg::*;

	stat_t mem [REGIONS];
	stat_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule : nrtp_stat_mem

`default_nettype wire

// File: rtl/nrtp_stack_mem.sv
// Nesting stack memory: two registered read ports (top and parent), one write port.
// No package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module nrtp_stack_mem #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 102
) (
	input  wire logic                      clk,
	input  wire logic                      re,
	input  wire logic [$clog2(DEPTH)-1:0]  raddr_a,
	input  wire logic [$clog2(DEPTH)-1:0]  raddr_b,
	output      logic [WIDTH-1:0]          rdata_a,
	output      logic [WIDTH-1:0]          rdata_b,
	input  wire logic                      we,
	input  wire logic [$clog2(DEPTH)-1:0]  waddr,
	input  wire logic [WIDTH-1:0]          wdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_a_q;
	logic [WIDTH-1:0] rdata_b_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a_q <= mem[raddr_a];
			rdata_b_q <= mem[raddr_b];
		end
	end

	assign rdata_a = rdata_a_q;
	assign rdata_b = rdata_b_q;

endmodule : nrtp_stack_mem

`default_nettype wire

// File: rtl/nested_region_time_profiler.sv
// Nested region time profiler, top level: control, arithmetic, config registers.
// Depends on nrtp_pkg, nrtp_stat_mem and nrtp_stack_mem.
// done is registered from state S_WB, entered from S_CALC after an item is accepted.
// busy holds off a new item until the last has passed the stat read-modify-write.
// A successful clear adds a zeroing sweep of every stat memory entry (busy high).
// Reset: async, active low; busy stays high while the stat memory
// is zeroed. done is a single-cycle strobe; the receiver cannot stall it.
`timescale 1ns / 1ps
`default_nettype none

module nested_region_time_profiler #(
	parameter int REGIONS     = 64,
	parameter int STACK_DEPTH = 16,
	parameter int TIME_BITS   = 48
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	output      logic                               busy,
	input  wire logic                               cfg_we,
	input  wire logic                               cfg_index,
	input  wire logic [nrtp_pkg::CFG_W-1:0]         cfg_wdata,
	input  wire logic [1:0]                         op,
	input  wire logic [nrtp_pkg::ID_W-1:0]          region_id,
	input  wire logic [nrtp_pkg::TS_W-1:0]          timestamp,
	output      logic                               done,
	output      logic [nrtp_pkg::STATUS_W-1:0]      status,
	output      logic [nrtp_pkg::ID_W-1:0]          region_id_res,
	output      logic [nrtp_pkg::CNT_W-1:0]         count,
	output      logic [nrtp_pkg::TOT_W-1:0]         inclusive_total,
	output      logic [nrtp_pkg::TOT_W-1:0]         exclusive_total,
	output      logic [nrtp_pkg::DEPTH_W-1:0]       nesting_depth,
	output      logic [nrtp_pkg::TS_W-1:0]          session_elapsed
);
	import nrtp_pkg::*;

	localparam int IW  = $clog2(REGIONS);
	localparam int SAW = $clog2(STACK_DEPTH);
	localparam int SPW = $clog2(STACK_DEPTH + 1);
	localparam int TW  = TIME_BITS;
	localparam int SW  = ID_W + 2 * TW;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_CALC  = 2'd1;
	localparam logic [1:0] S_WB    = 2'd2;
	localparam logic [1:0] S_SWEEP = 2'd3;

	logic [1:0]       state_q;
	logic [IW-1:0]    clr_q;
	logic             enable_q;
	logic [CFG_W-1:0] regions_q;
	logic [SPW-1:0]   sp_q;
	logic [TW-1:0]    session_q;

	logic [1:0]       op_q;
	logic [ID_W-1:0]  id_q;
	logic [TW-1:0]    ts_q;
	logic             vld_q;

	logic [STATUS_W-1:0] status_s2;
	logic [TW-1:0]       elapsed_s2;
	logic [TW-1:0]       excl_d_s2;

	logic                done_q;
	logic [STATUS_W-1:0] status_q;
	logic [ID_W-1:0]     id_res_q;
	logic [CNT_W-1:0]    count_q;
	logic [TOT_W-1:0]    incl_q;
	logic [TOT_W-1:0]    excl_q;
	logic [DEPTH_W-1:0]  depth_q;
	logic [TS_W-1:0]     sess_el_q;

	logic accept;
	logic in_vld;

	stat_t          stat_rd;
	stat_t          stat_new;
	stat_t          stat_wdata;
	logic           stat_we;
	logic [IW-1:0]  stat_waddr;

	logic [SW-1:0]  stk_top_rd;
	logic [SW-1:0]  stk_par_rd;
	logic           stk_we;
	logic [SAW-1:0] stk_waddr;
	logic [SW-1:0]  stk_wdata;

	logic [ID_W-1:0] top_region;
	logic [TW-1:0]   top_start;
	logic [TW-1:0]   top_child;
	logic [ID_W-1:0] par_region;
	logic [TW-1:0]   par_start;
	logic [TW-1:0]   par_child;

	logic [TW+1:0]       diff_full;
	logic                neg_time;
	logic [STATUS_W-1:0] status_calc;

	logic                ok;
	logic [TOT_W:0]      incl_sum;
	logic [TOT_W:0]      excl_sum;
	logic [TW:0]         child_sum;
	logic [TW-1:0]       child_new;
	logic [SPW-1:0]      sp_next;
	logic                clear_ok;
	logic [TS_W-1:0]     sess_el;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign in_vld = ({1'b0, region_id} < regions_q) && (32'(region_id) < 32'(REGIONS));

	// memories
	nrtp_stat_mem #(
		.REGIONS (REGIONS)
	) u_stat_mem (
		.clk   (clk),
		.re    (accept),
		.raddr (IW'(region_id)),
		.rdata (stat_rd),
		.we    (stat_we),
		.waddr (stat_waddr),
		.wdata (stat_wdata)
	);

	nrtp_stack_mem #(
		.DEPTH (STACK_DEPTH),
		.WIDTH (SW)
	) u_stack_mem (
		.clk     (clk),
		.re      (accept),
		.raddr_a (SAW'(sp_q - SPW'(1))),
		.raddr_b (SAW'(sp_q - SPW'(2))),
		.rdata_a (stk_top_rd),
		.rdata_b (stk_par_rd),
		.we      (stk_we),
		.waddr   (stk_waddr),
		.wdata   (stk_wdata)
	);

	assign top_region = stk_top_rd[SW-1 -: ID_W];
	assign top_start  = stk_top_rd[2*TW-1 -: TW];
	assign top_child  = stk_top_rd[TW-1:0];
	assign par_region = stk_par_rd[SW-1 -: ID_W];
	assign par_start  = stk_par_rd[2*TW-1 -: TW];
	assign par_child  = stk_par_rd[TW-1:0];

	// check stage
	assign diff_full = (TW+2)'(ts_q) - (TW+2)'(top_start) - (TW+2)'(top_child);
	assign neg_time  = (ts_q < top_start) || diff_full[TW+1];

	always_comb begin
		status_calc = ST_OK;
		unique case (op_q)
			OP_START: begin
				if (!enable_q)                          status_calc = ST_DISABLED;
				else if (!vld_q)                        status_calc = ST_BAD_REGION;
				else if (sp_q >= SPW'(STACK_DEPTH))     status_calc = ST_OVERFLOW;
			end
			OP_END: begin
				if (!enable_q)                          status_calc = ST_DISABLED;
				else if (!vld_q)                        status_calc = ST_BAD_REGION;
				else if (sp_q == '0)                    status_calc = ST_UNDERFLOW;
				else if (top_region != id_q)            status_calc = ST_MISMATCH;
				else if (neg_time)                      status_calc = ST_NEG_TIME;
			end
			OP_CLEAR: begin
				if (sp_q != '0)                         status_calc = ST_NESTED_CLR;
			end
			OP_READ: begin
				if (!vld_q)                             status_calc = ST_BAD_REGION;
			end
		endcase
	end

	// write-back stage
	assign ok        = (status_s2 == ST_OK);
	assign clear_ok  = ok && (op_q == OP_CLEAR);
	assign incl_sum  = (TOT_W+1)'(stat_rd.incl) + (TOT_W+1)'(elapsed_s2);
	assign excl_sum  = (TOT_W+1)'(stat_rd.excl) + (TOT_W+1)'(excl_d_s2);
	assign child_sum = (TW+1)'(par_child) + (TW+1)'(elapsed_s2);
	assign child_new = child_sum[TW] ? '1 : child_sum[TW-1:0];

	always_comb begin
		stat_new = stat_rd;
		sp_next  = sp_q;
		if (ok && op_q == OP_START) begin
			if (!(&stat_rd.count)) stat_new.count = stat_rd.count + CNT_W'(1);
			sp_next = sp_q + SPW'(1);
		end
		if (ok && op_q == OP_END) begin
			stat_new.incl = incl_sum[TOT_W] ? '1 : incl_sum[TOT_W-1:0];
			stat_new.excl = excl_sum[TOT_W] ? '1 : excl_sum[TOT_W-1:0];
			sp_next       = sp_q - SPW'(1);
		end
	end

	always_comb begin
		if (state_q == S_SWEEP) begin
			stat_we    = 1'b1;
			stat_waddr = clr_q;
			stat_wdata = '0;
		end else begin
			stat_we    = (state_q == S_WB) && ok && (op_q == OP_START || op_q == OP_END);
			stat_waddr = IW'(id_q);
			stat_wdata = stat_new;
		end
	end

	always_comb begin
		stk_we    = 1'b0;
		stk_waddr = SAW'(sp_q);
		stk_wdata = {id_q, ts_q, {TW{1'b0}}};
		if (state_q == S_WB && ok) begin
			if (op_q == OP_START) begin
				stk_we = 1'b1;
			end else if (op_q == OP_END && sp_q >= SPW'(2)) begin
				stk_we    = 1'b1;
				stk_waddr = SAW'(sp_q - SPW'(2));
				stk_wdata = {par_region, par_start, child_new};
			end
		end
	end

	always_comb begin
		if (clear_ok || ts_q < session_q) begin
			sess_el = '0;
		end else begin
			sess_el = TS_W'(ts_q - session_q);
		end
	end

	// control and state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_SWEEP;
			clr_q     <= '0;
			enable_q  <= 1'b0;
			regions_q <= CFG_W'(64);
			sp_q      <= '0;
			session_q <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q <= (state_q == S_WB);
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_ENABLE:  enable_q  <= cfg_wdata[0];
					CFG_REGIONS: regions_q <= cfg_wdata;
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) state_q <= S_CALC;
				end
				S_CALC: begin
					state_q <= S_WB;
				end
				S_WB: begin
					sp_q   <= sp_next;
					if (clear_ok) begin
						session_q <= ts_q;
						clr_q     <= '0;
						state_q   <= S_SWEEP;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_SWEEP: begin
					clr_q <= clr_q + IW'(1);
					if (clr_q == IW'(REGIONS - 1)) state_q <= S_IDLE;
				end
			endcase
		end
	end

	// item and pipeline payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= op;
			id_q  <= region_id;
			ts_q  <= TW'(timestamp);
			vld_q <= in_vld;
		end
		if (state_q == S_CALC) begin
			status_s2  <= status_calc;
			elapsed_s2 <= ts_q - top_start;
			excl_d_s2  <= diff_full[TW-1:0];
		end
		if (state_q == S_WB) begin
			status_q  <= status_s2;
			id_res_q  <= id_q;
			depth_q   <= DEPTH_W'(sp_next);
			sess_el_q <= sess_el;
			if (vld_q && !clear_ok) begin
				count_q <= stat_new.count;
				incl_q  <= stat_new.incl;
				excl_q  <= stat_new.excl;
			end else begin
				count_q <= '0;
				incl_q  <= '0;
				excl_q  <= '0;
			end
		end
	end

	assign done            = done_q;
	assign status          = status_q;
	assign region_id_res   = id_res_q;
	assign count           = count_q;
	assign inclusive_total = incl_q;
	assign exclusive_total = excl_q;
	assign nesting_depth   = depth_q;
	assign session_elapsed = sess_el_q;

endmodule : nested_region_time_profiler

`default_nettype wire

// File: dv/nested_region_time_profiler_tb.sv
// Testbench for nested_region_time_profiler: directed corner cases, then random
// nested start/end sequences with noise, checked against a scoreboard predictor.
// Depends on nrtp_pkg and the nested_region_time_profiler RTL.
`timescale 1ns / 1ps

module nested_region_time_profiler_tb;
	import nrtp_pkg::*;

	localparam int NEST_MAX = 16;
	localparam int REGION_SLOTS = 64;
	localparam logic [TS_W-1:0] TICK_MAX = '1;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ID_W-1:0]     rid;
		logic [CNT_W-1:0]    cnt;
		logic [TOT_W-1:0]    incl;
		logic [TOT_W-1:0]    excl;
		logic [DEPTH_W-1:0]  depth;
		logic [TS_W-1:0]     elapsed;
	} stat_report_t;

	class region_profile_checker;
		bit                  enabled;
		int                  region_limit;
		logic [ID_W-1:0]     open_region [NEST_MAX];
		logic [TS_W-1:0]     open_start [NEST_MAX];
		logic [TS_W-1:0]     open_child [NEST_MAX];
		int                  open_depth;
		logic [CNT_W-1:0]    hits [REGION_SLOTS];
		logic [TOT_W-1:0]    incl_ticks [REGION_SLOTS];
		logic [TOT_W-1:0]    excl_ticks [REGION_SLOTS];
		logic [TS_W-1:0]     session_t0;
		stat_report_t        expected_reports [$];
		int                  errors;

		function new();
			enabled = 1'b0;
			region_limit = 64;
			open_depth = 0;
			session_t0 = '0;
			errors = 0;
			foreach (hits[i]) begin
				hits[i] = '0;
				incl_ticks[i] = '0;
				excl_ticks[i] = '0;
			end
		endfunction

		function void write_register(logic idx, logic [CFG_W-1:0] val);
			if (idx == CFG_ENABLE)
				enabled = val[0];
			else
				region_limit = int'(val);
		endfunction

		function bit id_ok(logic [ID_W-1:0] id);
			return int'(id) < region_limit && int'(id) < REGION_SLOTS;
		endfunction

		function logic [TOT_W-1:0] sat_sum(logic [TOT_W-1:0] a, logic [TOT_W-1:0] b);
			logic [TOT_W:0] s;
			s = {1'b0, a} + {1'b0, b};
			return s[TOT_W] ? '1 : s[TOT_W-1:0];
		endfunction

		function void note_event(logic [1:0] e_op, logic [ID_W-1:0] id, logic [TS_W-1:0] ts);
			logic [STATUS_W-1:0] st;
			int                  top;
			logic [TS_W-1:0]     el;
			logic [TS_W-1:0]     ch;
			logic [TS_W:0]       c;
			stat_report_t        r;
			st = ST_OK;
			case (e_op)
				OP_START: begin
					if (!enabled)
						st = ST_DISABLED;
					else if (!id_ok(id))
						st = ST_BAD_REGION;
					else if (open_depth >= NEST_MAX)
						st = ST_OVERFLOW;
					else begin
						open_region[open_depth] = id;
						open_start[open_depth] = ts;
						open_child[open_depth] = '0;
						open_depth++;
						if (hits[id] != '1)
							hits[id] = hits[id] + 1'b1;
					end
				end
				OP_END: begin
					top = open_depth - 1;
					if (!enabled)
						st = ST_DISABLED;
					else if (!id_ok(id))
						st = ST_BAD_REGION;
					else if (open_depth == 0)
						st = ST_UNDERFLOW;
					else if (open_region[top] != id)
						st = ST_MISMATCH;
					else if (ts < open_start[top])
						st = ST_NEG_TIME;
					else begin
						el = ts - open_start[top];
						ch = open_child[top];
						if (ch > el)
							st = ST_NEG_TIME;
						else begin
							open_depth = top;
							incl_ticks[id] = sat_sum(incl_ticks[id], TOT_W'(el));
							excl_ticks[id] = sat_sum(excl_ticks[id], TOT_W'(el - ch));
							if (top > 0) begin
								c = {1'b0, open_child[top-1]} + {1'b0, el};
								open_child[top-1] = c[TS_W] ? TICK_MAX : c[TS_W-1:0];
							end
						end
					end
				end
				OP_CLEAR: begin
					if (open_depth != 0)
						st = ST_NESTED_CLR;
					else begin
						foreach (hits[i]) begin
							hits[i] = '0;
							incl_ticks[i] = '0;
							excl_ticks[i] = '0;
						end
						session_t0 = ts;
					end
				end
				default: begin
					st = id_ok(id) ? ST_OK : ST_BAD_REGION;
				end
			endcase
			r.status = st;
			r.rid = id;
			r.cnt = id_ok(id) ? hits[id] : '0;
			r.incl = id_ok(id) ? incl_ticks[id] : '0;
			r.excl = id_ok(id) ? excl_ticks[id] : '0;
			r.depth = DEPTH_W'(open_depth);
			r.elapsed = (ts >= session_t0) ? ts - session_t0 : '0;
			expected_reports.insert(expected_reports.size(), r);
		endfunction

		function void check_report(stat_report_t got);
			stat_report_t want;
			if (expected_reports.size() == 0) begin
				if (errors < 10)
					$display("%0t: result with nothing expected, id %0d status %0d",
						$time, got.rid, got.status);
				errors++;
				return;
			end
			want = expected_reports.pop_front();
			if (got !== want) begin
				if (errors < 10) begin
					$display("%0t: mismatch (expected/actual) status %0d/%0d id %0d/%0d",
						$time, want.status, got.status, want.rid, got.rid);
					$display("  count %0d/%0d incl %h/%h excl %h/%h",
						want.cnt, got.cnt, want.incl, got.incl, want.excl, got.excl);
					$display("  depth %0d/%0d elapsed %h/%h",
						want.depth, got.depth, want.elapsed, got.elapsed);
				end
				errors++;
			end
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	logic                cfg_we = 1'b0;
	logic                cfg_index = 1'b0;
	logic [CFG_W-1:0]    cfg_wdata = '0;
	logic [1:0]          op = OP_READ;
	logic [ID_W-1:0]     region_id = '0;
	logic [TS_W-1:0]     timestamp = '0;
	logic                done;
	logic [STATUS_W-1:0] status;
	logic [ID_W-1:0]     region_id_res;
	logic [CNT_W-1:0]    count;
	logic [TOT_W-1:0]    inclusive_total;
	logic [TOT_W-1:0]    exclusive_total;
	logic [DEPTH_W-1:0]  nesting_depth;
	logic [TS_W-1:0]     session_elapsed;

	region_profile_checker prof;
	logic [TS_W-1:0]       now;

	nested_region_time_profiler dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.op(op),
		.region_id(region_id),
		.timestamp(timestamp),
		.done(done),
		.status(status),
		.region_id_res(region_id_res),
		.count(count),
		.inclusive_total(inclusive_total),
		.exclusive_total(exclusive_total),
		.nesting_depth(nesting_depth),
		.session_elapsed(session_elapsed)
	);

	always #5 clk = ~clk;

	always @(negedge clk) begin
		stat_report_t got;
		if (arst_n && done) begin
			got.status = status;
			got.rid = region_id_res;
			got.cnt = count;
			got.incl = inclusive_total;
			got.excl = exclusive_total;
			got.depth = nesting_depth;
			got.elapsed = session_elapsed;
			prof.check_report(got);
		end
	end

	task automatic wait_ready();
		@(negedge clk);
		while (busy)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (prof.expected_reports.size() != 0)
			@(posedge clk);
		wait_ready();
	endtask

	task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		prof.write_register(idx, val);
	endtask

	// Called at a rising edge; returns at the edge where the transfer happened.
	task automatic send_event(input logic [1:0] e_op, input logic [ID_W-1:0] e_id,
			input logic [TS_W-1:0] e_ts, input int idle_pct);
		bit taken;
		if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(0, 99) < idle_pct);
		end
		op <= e_op;
		region_id <= e_id;
		timestamp <= e_ts;
		start <= 1'b1;
		do begin
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
		end while (!taken);
		prof.note_event(e_op, e_id, e_ts);
	endtask

	task automatic run_directed();
		send_event(OP_START, 6'd0, 48'd100, 0);
		send_event(OP_END, 6'd0, 48'd100, 0);
		send_event(OP_READ, 6'd63, 48'd0, 0);
		send_event(OP_CLEAR, 6'd5, 48'd10, 0);
		drain();
		write_reg(CFG_ENABLE, 7'd1);
		send_event(OP_END, 6'd3, 48'd20, 0);
		send_event(OP_START, 6'd63, 48'd0, 0);
		send_event(OP_END, 6'd62, 48'd30, 0);
		// two full-range children push the parent's child time into saturation
		send_event(OP_START, 6'd1, 48'd0, 0);
		send_event(OP_END, 6'd1, TICK_MAX, 0);
		send_event(OP_START, 6'd1, 48'd0, 0);
		send_event(OP_END, 6'd1, TICK_MAX, 0);
		send_event(OP_END, 6'd63, 48'd5, 0);
		send_event(OP_START, 6'd2, 48'd50, 0);
		send_event(OP_END, 6'd2, 48'd40, 0);
		send_event(OP_END, 6'd2, 48'd50, 0);
		send_event(OP_CLEAR, 6'd0, 48'd7, 0);
		send_event(OP_END, 6'd63, TICK_MAX, 0);
		send_event(OP_CLEAR, 6'd63, TICK_MAX, 0);
		send_event(OP_READ, 6'd17, 48'd1000, 0);
		drain();
		write_reg(CFG_REGIONS, 7'd1);
		send_event(OP_START, 6'd1, 48'd2000, 0);
		send_event(OP_END, 6'd1, 48'd2000, 0);
		send_event(OP_READ, 6'd63, 48'd2000, 0);
		send_event(OP_START, 6'd0, TICK_MAX, 0);
		send_event(OP_END, 6'd0, TICK_MAX, 0);
		send_event(OP_CLEAR, 6'd0, 48'd0, 0);
	endtask

	// Mostly well-formed nesting driven by the predicted stack, plus noise.
	task automatic pick_event(input int bias, output logic [1:0] e_op,
			output logic [ID_W-1:0] e_id, output logic [TS_W-1:0] e_ts);
		int            r;
		int            lim;
		logic [TS_W:0] nx;
		logic [TS_W-1:0] back;
		lim = (prof.region_limit > REGION_SLOTS) ? REGION_SLOTS : prof.region_limit;
		if (prof.open_depth == 0 && $urandom_range(0, 39) == 0)
			now = {16'($urandom), 32'($urandom)};
		else begin
			nx = {1'b0, now} + (($urandom_range(0, 9) == 0) ?
				(TS_W+1)'($urandom_range(0, 1 << 24)) : (TS_W+1)'($urandom_range(0, 40)));
			now = nx[TS_W] ? TICK_MAX : nx[TS_W-1:0];
		end
		r = $urandom_range(0, 99);
		e_ts = now;
		e_id = ID_W'($urandom_range(0, lim - 1));
		e_op = OP_READ;
		if (r < bias)
			e_op = OP_START;
		else if (r < 85) begin
			if (prof.open_depth > 0) begin
				e_op = OP_END;
				e_id = prof.open_region[prof.open_depth - 1];
			end else
				e_op = ($urandom_range(0, 7) == 0) ? OP_END : OP_START;
		end else if (r < 89)
			e_id = ID_W'($urandom);
		else if (r < 92) begin
			e_op = OP_CLEAR;
			e_id = ID_W'($urandom);
		end else if (r < 95) begin
			e_op = OP_END;
			e_id = ID_W'($urandom);
		end else if (r < 97) begin
			e_op = OP_START;
			e_id = ID_W'($urandom);
		end else begin
			// end stamped earlier than the current time
			e_op = OP_END;
			if (prof.open_depth > 0)
				e_id = prof.open_region[prof.open_depth - 1];
			back = TS_W'($urandom_range(1, 200));
			e_ts = (now > back) ? now - back : '0;
		end
	endtask

	initial begin
		logic [1:0]      e_op;
		logic [ID_W-1:0] e_id;
		logic [TS_W-1:0] e_ts;
		int              idle;
		int              bias;
		int              n;
		int              lim;
		prof = new();
		now = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		wait_ready();
		run_directed();
		now = '0;
		for (int s = 0; s < 15; s++) begin
			idle = (s < 5) ? 24 : ((s < 10) ? 54 : 0);
			bias = (s % 3 == 0) ? 45 : ((s % 3 == 1) ? 60 : 35);
			case (s % 5)
				0, 3: lim = 64;
				1: lim = 1;
				default: lim = $urandom_range(2, 63);
			endcase
			n = (s % 7 == 3) ? 30 : 115;
			drain();
			write_reg(CFG_ENABLE, (s % 7 == 3) ? 7'd0 : 7'd1);
			write_reg(CFG_REGIONS, CFG_W'(lim));
			for (int i = 0; i < n; i++) begin
				pick_event(bias, e_op, e_id, e_ts);
				send_event(e_op, e_id, e_ts, idle);
			end
			// close every open region before the settings change
			for (int k = 0; k <= NEST_MAX && prof.open_depth > 0; k++)
				send_event(OP_END, prof.open_region[prof.open_depth - 1], now, idle);
		end
		drain();
		repeat (8) @(posedge clk);
		if (prof.errors == 0 && prof.expected_reports.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

// File: sim.f
rtl/nrtp_pkg.sv
rtl/nrtp_stat_mem.sv
rtl/nrtp_stack_mem.sv
rtl/nested_region_time_profiler.sv
dv/nested_region_time_profiler_tb.sv
